>>> design/dbt_pkg.sv
`default_nettype none
package dbt_pkg;
  localparam int BLOCK_SHIFT_X_DEF = 7;
  localparam int BLOCK_SHIFT_Y_DEF = 6;
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;
  localparam int WW = 13;
  localparam int HW = 12;
  localparam logic [0:0] CFG_WIDTH = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;
  localparam logic REQ_INVAL = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_MARK, ST_SCAN, ST_RUN, ST_DOWN, ST_WIPE, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

>>> design/dirty_block_tracker.sv
`default_nettype none
// channel | ports                                  | handshake
// input   | in_req_type, in_rect_*                 | start & !busy
// result  | out_found, out_region_*                | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_data            | cfg_we
// The grid is one bit per block in a memory of rows, one row word per
// address. Invalidate: each covered row is read, then written back.
// Take-next: blocks are read column by column, the run is extended, rows
// are grown and cleared (read, then write back), and the region is clipped;
// the result shows in the cycle after the clip. The worst case is set by
// the single row read port. Reset and each config write clear all MAX_ROWS rows.
// The receiver cannot stall; each result shows for one cycle.
module dirty_block_tracker #(
  parameter int BLOCK_SHIFT_X = dbt_pkg::BLOCK_SHIFT_X_DEF,
  parameter int BLOCK_SHIFT_Y = dbt_pkg::BLOCK_SHIFT_Y_DEF,
  parameter int MAX_COLUMNS = dbt_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS = dbt_pkg::MAX_ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic in_req_type,
  input  wire logic signed [15:0] in_rect_left,
  input  wire logic signed [15:0] in_rect_top,
  input  wire logic signed [15:0] in_rect_right,
  input  wire logic signed [15:0] in_rect_bottom,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [12:0] cfg_data,
  output logic out_valid,
  output logic out_found,
  output logic [12:0] out_region_left,
  output logic [11:0] out_region_top,
  output logic [12:0] out_region_right,
  output logic [11:0] out_region_bottom
);
  import dbt_pkg::*;
  localparam int XB = $clog2(MAX_COLUMNS);
  localparam int YB = $clog2(MAX_ROWS);
  localparam int XC = $clog2(MAX_COLUMNS + 1);
  localparam int YC = $clog2(MAX_ROWS + 1);

  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rd_r, wr_data;
  logic [YB-1:0] rd_addr, wr_addr;
  logic wr_en;

  state_t st_r, st_nxt;
  logic [WW-1:0] sw_r;
  logic [HW-1:0] sh_r;
  logic [XC-1:0] cols, x_r, x_nxt, xx_r, xx_nxt, cl_r, cr_r;
  logic [YC-1:0] rows, y_r, y_nxt, yy_r, yy_nxt, ct_r, cb_r;
  logic [MAX_COLUMNS-1:0] span_r, span_nxt;
  logic [XC-1:0] cl_nxt, cr_nxt;
  logic [YC-1:0] ct_nxt, cb_nxt;
  logic rdv_r, rdv_nxt;
  logic ov_nxt, of_nxt;
  logic [12:0] ol_nxt, or_nxt;
  logic [11:0] ot_nxt, ob_nxt;
  logic [YB-1:0] cnt_r, cnt_nxt;

  logic signed [16:0] l, t, r, b;
  logic signed [16:0] cl17, cr17, ct17, cb17;
  logic empty;
  logic [XB+BLOCK_SHIFT_X:0] pl, pr;
  logic [YB+BLOCK_SHIFT_Y:0] pt, pb;

  always_comb begin
    logic [WW-1:0] c;
    logic [HW-1:0] rr;
    c = (sw_r >> BLOCK_SHIFT_X) + WW'(1);
    rr = (sh_r >> BLOCK_SHIFT_Y) + HW'(1);
    cols = (32'(c) > MAX_COLUMNS) ? XC'(MAX_COLUMNS) : XC'(c);
    rows = (32'(rr) > MAX_ROWS) ? YC'(MAX_ROWS) : YC'(rr);
  end

  always_comb begin
    l = (in_rect_left < 0) ? 17'sd0 : 17'(in_rect_left);
    t = (in_rect_top < 0) ? 17'sd0 : 17'(in_rect_top);
    r = (17'(in_rect_right) > $signed({4'd0, sw_r})) ? $signed({4'd0, sw_r})
        : 17'(in_rect_right);
    b = (17'(in_rect_bottom) > $signed({5'd0, sh_r})) ? $signed({5'd0, sh_r})
        : 17'(in_rect_bottom);
    empty = (l >= r) || (t >= b);
    cl17 = l >>> BLOCK_SHIFT_X;
    cr17 = (r - 17'sd1) >>> BLOCK_SHIFT_X;
    ct17 = t >>> BLOCK_SHIFT_Y;
    cb17 = (b - 17'sd1) >>> BLOCK_SHIFT_Y;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      sw_r <= WW'(640);
      sh_r <= HW'(480);
      cnt_r <= '0;
      out_valid <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      rdv_r <= rdv_nxt;
      out_valid <= ov_nxt;
      if (cfg_we && cfg_index == CFG_WIDTH) sw_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_HEIGHT) sh_r <= cfg_data[HW-1:0];
    end
    x_r <= x_nxt; y_r <= y_nxt; xx_r <= xx_nxt; yy_r <= yy_nxt;
    cl_r <= cl_nxt; cr_r <= cr_nxt; ct_r <= ct_nxt; cb_r <= cb_nxt;
    span_r <= span_nxt;
    out_found <= of_nxt;
    out_region_left <= ol_nxt; out_region_top <= ot_nxt;
    out_region_right <= or_nxt; out_region_bottom <= ob_nxt;
  end

  assign busy = (st_r != ST_IDLE);

  always_comb begin
    logic [MAX_COLUMNS-1:0] m;
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    x_nxt = x_r; y_nxt = y_r; xx_nxt = xx_r; yy_nxt = yy_r;
    cl_nxt = cl_r; cr_nxt = cr_r; ct_nxt = ct_r; cb_nxt = cb_r;
    span_nxt = span_r;
    rdv_nxt = 1'b0;
    rd_addr = y_r[YB-1:0];
    wr_en = 1'b0; wr_addr = cnt_r; wr_data = '0;
    ov_nxt = 1'b0; of_nxt = 1'b0;
    ol_nxt = '0; ot_nxt = '0; or_nxt = '0; ob_nxt = '0;
    pl = '0; pr = '0; pt = '0; pb = '0;
    m = '0;
    unique case (st_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        cnt_nxt = cnt_r + YB'(1);
        if (32'(cnt_r) == MAX_ROWS - 1) begin
          st_nxt = ST_IDLE;
          cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_INVAL) begin
            if (!empty && 32'(ct17) < MAX_ROWS && 32'(cl17) < MAX_COLUMNS) begin
              cl_nxt = XC'(cl17);
              cr_nxt = (32'(cr17) >= MAX_COLUMNS) ? XC'(MAX_COLUMNS - 1) : XC'(cr17);
              ct_nxt = YC'(ct17);
              cb_nxt = (32'(cb17) >= MAX_ROWS) ? YC'(MAX_ROWS - 1) : YC'(cb17);
              yy_nxt = YC'(ct17);
              st_nxt = ST_MARK;
            end
          end else begin
            x_nxt = '0; y_nxt = '0;
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_MARK: begin
        rd_addr = yy_r[YB-1:0];
        if (rdv_r) begin
          for (int i = 0; i < MAX_COLUMNS; i++)
            m[i] = (XC'(i) >= cl_r) && (XC'(i) <= cr_r);
          wr_en = 1'b1; wr_addr = yy_r[YB-1:0]; wr_data = rd_r | m;
          if (yy_r == cb_r) st_nxt = ST_IDLE;
          else yy_nxt = yy_r + YC'(1);
        end else rdv_nxt = 1'b1;
      end
      ST_SCAN: begin
        rd_addr = y_r[YB-1:0];
        if (x_r >= cols) begin
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end else if (rdv_r) begin
          if (rd_r[x_r[XB-1:0]]) begin
            xx_nxt = x_r;
            span_nxt = '0;
            st_nxt = ST_RUN;
          end else if (y_r + YC'(1) >= rows) begin
            y_nxt = '0; x_nxt = x_r + XC'(1);
          end else y_nxt = y_r + YC'(1);
        end else rdv_nxt = 1'b1;
      end
      ST_RUN: begin
        if (xx_r < cols && rd_r[xx_r[XB-1:0]]) begin
          span_nxt = span_r;
          span_nxt[xx_r[XB-1:0]] = 1'b1;
          xx_nxt = xx_r + XC'(1);
        end else begin
          yy_nxt = y_r;
          st_nxt = ST_DOWN;
        end
      end
      ST_DOWN: begin
        rd_addr = yy_r[YB-1:0];
        if (yy_r >= rows) st_nxt = ST_WIPE;
        else if (rdv_r) begin
          if ((rd_r & span_r) == span_r) begin
            wr_en = 1'b1; wr_addr = yy_r[YB-1:0]; wr_data = rd_r & ~span_r;
            yy_nxt = yy_r + YC'(1);
          end else st_nxt = ST_WIPE;
        end else rdv_nxt = 1'b1;
      end
      ST_WIPE: begin
        pl = (XB+BLOCK_SHIFT_X+1)'(x_r) << BLOCK_SHIFT_X;
        pr = (XB+BLOCK_SHIFT_X+1)'(xx_r) << BLOCK_SHIFT_X;
        pt = (YB+BLOCK_SHIFT_Y+1)'(y_r) << BLOCK_SHIFT_Y;
        pb = (YB+BLOCK_SHIFT_Y+1)'(yy_r) << BLOCK_SHIFT_Y;
        if (32'(pr) > 32'(sw_r)) pr = (XB+BLOCK_SHIFT_X+1)'(sw_r);
        if (32'(pb) > 32'(sh_r)) pb = (YB+BLOCK_SHIFT_Y+1)'(sh_r);
        if (pr <= pl || pb <= pt) st_nxt = ST_SCAN;
        else begin
          ov_nxt = 1'b1; of_nxt = 1'b1;
          ol_nxt = 13'(pl); or_nxt = 13'(pr);
          ot_nxt = 12'(pt); ob_nxt = 12'(pb);
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      st_nxt = ST_CLEAR;
      cnt_nxt = '0;
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/tb_dirty_block_tracker.sv
`timescale 1ns / 1ps
module tb_dirty_block_tracker;
  import dbt_pkg::*;

  typedef struct packed {
    logic        found;
    logic [12:0] left;
    logic [11:0] top;
    logic [12:0] right;
    logic [11:0] bottom;
  } region_t;

  typedef struct {
    logic        req;
    int          l, t, r, b;
    bit          typed;
    region_t     region;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = REQ_INVAL;
  logic signed [15:0] in_rect_left = '0, in_rect_top = '0;
  logic signed [15:0] in_rect_right = '0, in_rect_bottom = '0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_WIDTH;
  logic [12:0] cfg_data = '0;
  logic out_valid, out_found;
  logic [12:0] out_region_left, out_region_right;
  logic [11:0] out_region_top, out_region_bottom;

  dirty_block_tracker uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #600ms;
    $display("[dirty_block_tracker] ERROR");
    $finish;
  end

  // shadow state
  bit      dirty [64][64];
  int      scr_w = 640, scr_h = 480;
  region_t pending_regions[$];
  int      errors = 0, mismatches = 0, items_sent = 0, regions_seen = 0, found_seen = 0;
  int      cfg_writes = 0;
  bit      no_gaps = 0;

  function automatic void mark_rect(int l, int t, int r, int b);
    int cl, ct, cr, cb;
    if (l < 0) l = 0;
    if (t < 0) t = 0;
    if (r > scr_w) r = scr_w;
    if (b > scr_h) b = scr_h;
    if (l >= r || t >= b) return;
    cl = l >> 7; cr = (r - 1) >> 7; ct = t >> 6; cb = (b - 1) >> 6;
    for (int y = ct; y <= cb && y < 64; y++)
      for (int x = cl; x <= cr && x < 64; x++) dirty[y][x] = 1;
  endfunction

  function automatic region_t next_region();
    int cols, rows, xx, yy, run, depth, pl, pt, pr, pb;
    bit ok;
    region_t res;
    res = '0;
    cols = (scr_w >> 7) + 1; if (cols > 64) cols = 64;
    rows = (scr_h >> 6) + 1; if (rows > 64) rows = 64;
    for (int x = 0; x < cols; x++)
      for (int y = 0; y < rows; y++) begin
        if (!dirty[y][x]) continue;
        for (xx = x; xx < cols && dirty[y][xx]; xx++) ;
        run = xx - x;
        for (yy = y; yy < rows; yy++) begin
          ok = 1;
          for (xx = x; xx < x + run; xx++)
            if (!dirty[yy][xx]) ok = 0;
          if (!ok) break;
        end
        depth = yy - y;
        for (yy = y; yy < y + depth; yy++)
          for (xx = x; xx < x + run; xx++) dirty[yy][xx] = 0;
        pl = x << 7; pt = y << 6;
        pr = pl + (run << 7); pb = pt + (depth << 6);
        if (pr > scr_w) pr = scr_w;
        if (pb > scr_h) pb = scr_h;
        if (pr <= pl || pb <= pt) continue;
        res.found = 1; res.left = pl[12:0]; res.top = pt[11:0];
        res.right = pr[12:0]; res.bottom = pb[11:0];
        return res;
      end
    return res;
  endfunction

  task automatic send_item(logic req, int l, int t, int r, int b, bit typed,
                           region_t exp_r);
    int gap;
    region_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_rect_left <= l[15:0]; in_rect_top <= t[15:0];
    in_rect_right <= r[15:0]; in_rect_bottom <= b[15:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (req == REQ_TAKE) begin
      pred = next_region();
      if (typed && pred !== exp_r) begin
        errors++;
        $display("typed row disagrees with shadow: %h vs %h", exp_r, pred);
      end
      pending_regions.push_back(typed ? exp_r : pred);
    end else
      mark_rect($signed(l[15:0]), $signed(t[15:0]), $signed(r[15:0]), $signed(b[15:0]));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, int val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) scr_w = val & 13'h1FFF; else scr_h = val & 12'hFFF;
    foreach (dirty[y, x]) dirty[y][x] = 0;
    cfg_writes++;
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    region_t got, want;
    if (rst_n && out_valid) begin
      got = {out_found, out_region_left, out_region_top, out_region_right,
             out_region_bottom};
      regions_seen++;
      if (out_found) found_seen++;
      if (pending_regions.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
      end else begin
        want = pending_regions.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: exp found=%0d l=%0d t=%0d r=%0d b=%0d",
                      " got found=%0d l=%0d t=%0d r=%0d b=%0d"},
                     want.found, want.left, want.top, want.right, want.bottom,
                     got.found, got.left, got.top, got.right, got.bottom);
        end
      end
    end
  end

  function automatic int rand_coord(int lim);
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom));
      1: return -32768;
      2: return 32767;
      default: return $urandom_range(0, lim + 400) - 200;
    endcase
  endfunction

  stim_row_t dir_rows[$];
  int cfg_w_list[] = '{640, 1, 8191, 0, 129, 1000, 300, 640};
  int cfg_h_list[] = '{480, 4095, 1, 0, 65, 700, 200, 480};

  initial begin
    int l, t, r, b;
    logic req;
    stim_row_t row;
    region_t none_r;
    none_r = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (MAX_ROWS_DEF + 8) @(posedge clk);
    while (busy) @(posedge clk);

    // directed
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 1, none_r});
    dir_rows.push_back('{REQ_INVAL, -32768, -32768, 32767, 32767, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 1, {1'b1, 13'd0, 12'd0, 13'd640, 12'd480}});
    dir_rows.push_back('{REQ_TAKE, -1, -1, -1, -1, 1, none_r});
    dir_rows.push_back('{REQ_INVAL, 300, 100, 300, 200, 0, none_r});
    dir_rows.push_back('{REQ_INVAL, 100, 300, 200, 100, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 1, none_r});
    dir_rows.push_back('{REQ_INVAL, 639, 479, 640, 480, 0, none_r});
    dir_rows.push_back('{REQ_INVAL, 0, 0, 1, 1, 0, none_r});
    dir_rows.push_back('{REQ_INVAL, 130, 70, 400, 300, 0, none_r});
    dir_rows.push_back('{REQ_INVAL, 600, 0, 32767, 10, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 32767, -32768, 0, 0, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 0, none_r});
    dir_rows.push_back('{REQ_INVAL, 640, 480, 32767, 32767, 0, none_r});
    dir_rows.push_back('{REQ_TAKE, 0, 0, 0, 0, 1, none_r});
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.req, row.l, row.t, row.r, row.b, row.typed, row.region);
    end

    // random, several screen sizes
    for (int ph = 0; ph < cfg_w_list.size(); ph++) begin
      write_cfg(CFG_WIDTH, cfg_w_list[ph]);
      write_cfg(CFG_HEIGHT, cfg_h_list[ph]);
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (n == 100) drain();
        req = ($urandom_range(0, 99) < 35) ? REQ_TAKE : REQ_INVAL;
        l = rand_coord(scr_w); t = rand_coord(scr_h);
        r = rand_coord(scr_w); b = rand_coord(scr_h);
        if (req == REQ_INVAL && $urandom_range(0, 3) != 0) begin
          if (r < l) begin int s; s = l; l = r; r = s; end
          if (b < t) begin int s; s = t; t = b; b = s; end
        end
        send_item(req, l, t, r, b, 0, none_r);
      end
      no_gaps = 0;
    end

    drain();
    $display("sent %0d items over %0d register writes; %0d results checked, %0d with a region",
             items_sent, cfg_writes, regions_seen, found_seen);
    if (errors == 0 && pending_regions.size() == 0)
      $display("[dirty_block_tracker] OK");
    else
      $display("[dirty_block_tracker] ERROR");
    $finish;
  end
endmodule
